// File: src/chd_pkg.sv
// Package for the canonical Huffman bit decoder: item codes, field widths
// and the match record passed from the code tracker to the top level.
// Depends on nothing; every other file of the block refers to it.
`default_nettype none

package chd_pkg;

  // Default sizes of the tables; the top level takes them as parameters.
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int MAX_SYMBOLS_DEF  = 256;

  // Fixed widths of the payload fields and of the decode registers.
  localparam int ADDR_W  = 8;
  localparam int DATA_W  = 8;
  localparam int CODE_W  = 16;
  localparam int FIRST_W = 17;
  localparam int BASE_W  = 9;
  localparam int IDX_W   = 8;
  localparam int LEN_W   = 5;

  localparam logic [BASE_W-1:0] BASE_MAX = '1;

  // Kind of an input item, carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_COUNT  = 2'd0,
    ACT_SYMBOL = 2'd1,
    ACT_BIT    = 2'd2
  } action_t;

  // Outcome of one code bit.
  typedef struct packed {
    logic             valid;
    logic             error;
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] length;
  } match_t;

endpackage

`default_nettype wire

// File: src/canonical_huffman_bit_decoder.sv
// Canonical Huffman bit decoder, top level. Uses chd_pkg and chd_code_tracker.
// Throughput: one input item per cycle, sustained, while the output is taken.
// The result of the code bit that ends a code passes through the match register,
// then the symbol store read register, before it reaches the output.
// Reset (rst, synchronous, active high) clears the code counts, the decode in
// progress and both stages; the symbol store is not cleared.
`default_nettype none

module canonical_huffman_bit_decoder #(
  parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
  parameter int MAX_SYMBOLS  = chd_pkg::MAX_SYMBOLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // address[7:0], data[15:8], bit_req[16], zero[23:17]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // symbol[7:0], symbol_index[15:8],
                                          // length_used[20:16], zero[23:21]
  output logic             m_axis_tuser   // error[0]
);

  localparam int SYM_AW = $clog2(MAX_SYMBOLS);
  localparam int DW     = chd_pkg::DATA_W;

  // Unpack the input item.
  logic [chd_pkg::ADDR_W-1:0] address;
  logic [DW-1:0]              data;
  logic                       bit_req;
  chd_pkg::action_t           action;

  assign address = s_axis_tdata[7:0];
  assign data    = s_axis_tdata[15:8];
  assign bit_req = s_axis_tdata[16];
  assign action  = chd_pkg::action_t'(s_axis_tuser);

  logic accept;
  logic count_we;
  logic sym_we;
  logic bit_step;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Decode the item kind; the unused kind falls through and does nothing.
  always_comb begin
    count_we = 1'b0;
    sym_we   = 1'b0;
    bit_step = 1'b0;
    case (action)
      chd_pkg::ACT_COUNT:  count_we = accept;
      chd_pkg::ACT_SYMBOL: sym_we   = accept &&
                                      ({1'b0, address} < (chd_pkg::ADDR_W + 1)'(MAX_SYMBOLS));
      chd_pkg::ACT_BIT:    bit_step = accept;
      default: begin
      end
    endcase
  end

  // The tracker holds the count table and the running code, and reports
  // whether the bit being accepted ends a code (hit, overfull table or
  // too many bits).
  chd_pkg::match_t match;

  chd_code_tracker #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .count_we   (count_we),
    .count_addr (address),
    .count_data (data),
    .bit_step   (bit_step),
    .bit_in     (bit_req),
    .match      (match)
  );

  // Stage 1 holds a finished match until the symbol store can be read for it.
  // Stage 2 is the output register; the symbol read data lands there directly.
  // Both stages move together whenever the output is empty or being taken,
  // and stage 1 may still fill while the output is stalled, so one result
  // can wait at each stage.
  logic                           s1_valid;
  logic                           s1_error;
  logic [chd_pkg::IDX_W-1:0]      s1_index;
  logic [chd_pkg::LEN_W-1:0]      s1_length;

  logic                           out_valid;
  logic                           out_error;
  logic [chd_pkg::IDX_W-1:0]      out_index;
  logic [chd_pkg::LEN_W-1:0]      out_length;
  logic [DW-1:0]                  sym_rd;

  logic advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= bit_step && match.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_error  <= match.error;
      s1_index  <= match.index;
      s1_length <= match.length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_error  <= s1_error;
      out_index  <= s1_index;
      out_length <= s1_length;
    end
  end

  // Symbol store: one write port for symbol items, one registered read port
  // for stage 1. A write accepted in the same cycle as a read belongs to a
  // later item, so the read returning the old contents is what is wanted.
  logic [DW-1:0] sym_mem [MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[address[SYM_AW-1:0]] <= data;
    end
    if (advance && s1_valid) begin
      sym_rd <= sym_mem[s1_index[SYM_AW-1:0]];
    end
  end

  // An error result carries symbol zero.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_length, out_index, (out_error ? '0 : sym_rd)};
  assign m_axis_tuser  = out_error;

  // A waiting match is never dropped while the output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("stage 1 match lost during output stall");

  // Input is refused only when both stages hold results.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

  // A delivered result has a code length between one and the longest code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_length != '0) &&
                  (out_length <= chd_pkg::LEN_W'(MAX_CODE_LEN)))
    else $error("result length out of range");

  // An error result carries index zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_index == '0)
    else $error("error result with nonzero index");

  // A result leaves stage 1 only into an empty or draining output.
  assert property (@(posedge clk) disable iff (rst)
    $past(s1_valid) && $past(advance) && !$past(rst) |-> out_valid)
    else $error("stage 1 result did not reach the output");

endmodule

`default_nettype wire

// File: src/chd_code_tracker.sv
// Code tracker: holds the per-length code counts and the running code state,
// and decides for each code bit whether a code ends. Uses chd_pkg.
`default_nettype none

module chd_code_tracker #(
  parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
  parameter int MAX_SYMBOLS  = chd_pkg::MAX_SYMBOLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        count_we,
  input  wire logic [chd_pkg::ADDR_W-1:0]  count_addr,
  input  wire logic [chd_pkg::DATA_W-1:0]  count_data,
  input  wire logic                        bit_step,
  input  wire logic                        bit_in,
  output chd_pkg::match_t                  match
);

  localparam int CNT_AW = $clog2(MAX_CODE_LEN);
  localparam int FW     = chd_pkg::FIRST_W;
  localparam int BW     = chd_pkg::BASE_W;
  localparam int DW     = chd_pkg::DATA_W;

  logic [DW-1:0]                 counts [MAX_CODE_LEN];
  logic [chd_pkg::CODE_W-1:0]    code;
  logic [FW-1:0]                 first;
  logic [BW-1:0]                 base;
  logic [chd_pkg::LEN_W-1:0]     bits_taken;

  logic [chd_pkg::CODE_W-1:0]    code_next;
  logic [FW-1:0]                 first_next;
  logic [BW-1:0]                 base_next;
  logic [chd_pkg::LEN_W-1:0]     len;
  logic [DW-1:0]                 count;
  logic [FW-1:0]                 code_ext;
  logic [FW-1:0]                 diff;
  logic                          hit;
  logic [BW:0]                   idx_full;
  logic                          oversub;
  logic                          last_len;
  logic [FW-1:0]                 first_sum;
  logic [BW:0]                   base_sum;

  // The count of the current length sits at bits_taken, which is length - 1.
  assign len       = bits_taken + chd_pkg::LEN_W'(1);
  assign count     = counts[bits_taken[CNT_AW-1:0]];
  assign code_next = {code[chd_pkg::CODE_W-2:0], bit_in};
  assign code_ext  = {{(FW - chd_pkg::CODE_W){1'b0}}, code_next};
  assign diff      = code_ext - first;
  assign hit       = (code_ext >= first) && (diff < {{(FW - DW){1'b0}}, count});
  assign idx_full  = {1'b0, base} + {{(BW + 1 - DW){1'b0}}, diff[DW-1:0]};
  assign oversub   = idx_full >= (BW + 1)'(MAX_SYMBOLS);
  assign last_len  = len >= chd_pkg::LEN_W'(MAX_CODE_LEN);
  assign first_sum = first + {{(FW - DW){1'b0}}, count};
  assign first_next = {first_sum[FW-2:0], 1'b0};
  assign base_sum  = {1'b0, base} + {{(BW + 1 - DW){1'b0}}, count};
  assign base_next = base_sum[BW] ? chd_pkg::BASE_MAX : base_sum[BW-1:0];

  always_comb begin
    match.valid  = 1'b0;
    match.error  = 1'b0;
    match.index  = '0;
    match.length = len;
    if (hit) begin
      match.valid = 1'b1;
      match.error = oversub;
      match.index = oversub ? '0 : idx_full[chd_pkg::IDX_W-1:0];
    end else if (last_len) begin
      match.valid  = 1'b1;
      match.error  = 1'b1;
      match.length = chd_pkg::LEN_W'(MAX_CODE_LEN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        counts[i] <= '0;
      end
      code       <= '0;
      first      <= '0;
      base       <= '0;
      bits_taken <= '0;
    end else begin
      if (count_we && (count_addr < chd_pkg::ADDR_W'(MAX_CODE_LEN))) begin
        counts[count_addr[CNT_AW-1:0]] <= count_data;
      end
      if (bit_step) begin
        if (hit || last_len) begin
          code       <= '0;
          first      <= '0;
          base       <= '0;
          bits_taken <= '0;
        end else begin
          code       <= code_next;
          first      <= first_next;
          base       <= base_next;
          bits_taken <= len;
        end
      end
    end
  end

endmodule

`default_nettype wire
